[rtl/assert_macros.svh]
// assertion macros shared by the keypad rtl
// depends on a clock named clk and an active low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, quiet while in reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression that must never be true
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

[rtl/mkne_pkg.sv]
// types, codes and the key map for the keypad number entry block
// no dependencies
package mkne_pkg;

	localparam logic [15:0] SETTLE_RESET = 16'd1000;

	localparam logic PHASE_SETTLE = 1'b0;
	localparam logic PHASE_HOLD   = 1'b1;

	localparam logic [6:0] ASCII_0 = 7'h30;
	localparam logic [6:0] ASCII_9 = 7'h39;

	typedef struct packed {
		logic [3:0]  row_drive;
		logic        key_valid;
		logic [6:0]  key_code;
		logic        digit_taken;
		logic        entry_done;
		logic [31:0] number_value;
	} res_t;

	// ascii code of the key at row r, column c
	function automatic logic [6:0] key_ascii(input logic [1:0] r, input logic [1:0] c);
		logic [6:0] code;
		case ({r, c})
			4'd0:    code = 7'h37; // 7
			4'd1:    code = 7'h38; // 8
			4'd2:    code = 7'h39; // 9
			4'd3:    code = 7'h2f; // /
			4'd4:    code = 7'h34; // 4
			4'd5:    code = 7'h35; // 5
			4'd6:    code = 7'h36; // 6
			4'd7:    code = 7'h78; // x
			4'd8:    code = 7'h31; // 1
			4'd9:    code = 7'h32; // 2
			4'd10:   code = 7'h33; // 3
			4'd11:   code = 7'h2d; // -
			4'd12:   code = 7'h62; // b
			4'd13:   code = 7'h30; // 0
			4'd14:   code = 7'h3d; // =
			4'd15:   code = 7'h2b; // +
			default: code = 7'h00;
		endcase
		return code;
	endfunction

endpackage

[rtl/matrix_keypad_number_entry.sv]
// 4x4 matrix keypad scanner with decimal number entry, top level
// depends on mkne_pkg and assert_macros.svh
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, col_levels            | beats in
//  result   | out_valid, out_stall, row_drive, key_*,   | beats out
//           | digit_taken, entry_done, number_value     |
//  config   | cfg_wr_en, cfg_wr_data (settle ticks)     | writes in
//
// one beat per clock unless out_stall holds a full result register: an input register, one pass of scan logic,
// a result register; a beat passes the input register, then the result register; the result register sets the rate
// reset clears the scan state and the number, settle ticks return to 1000
// out_stall holds the result register; the input register still takes one beat behind it
`include "assert_macros.svh"

module matrix_keypad_number_entry
	import mkne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  col_levels,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  row_drive,
	output logic        key_valid,
	output logic [6:0]  key_code,
	output logic        digit_taken,
	output logic        entry_done,
	output logic [31:0] number_value
);

	// configuration
	logic [15:0] settle_ticks_q;

	// scan state
	logic        phase_q;
	logic [1:0]  row_q;
	logic [15:0] settle_cnt_q;
	logic [1:0]  held_col_q;
	logic [31:0] acc_q;

	// pipeline
	logic        vld_s1;
	logic [3:0]  col_s1;
	logic        vld_s2;
	res_t        res_s2;
	logic        adv_s1;

	// next state and result of the beat in the input register
	logic        phase_d;
	logic [1:0]  row_d;
	logic [15:0] settle_cnt_d;
	logic [1:0]  held_col_d;
	logic [31:0] acc_d;
	res_t        res_d;

	logic        low_found;
	logic [1:0]  low_col;
	logic [6:0]  code;
	logic        is_digit;
	logic [3:0]  digit_val;
	logic [31:0] acc_x10;

	// input beat moves on when the result register is free or being emptied
	assign adv_s1   = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ticks_q <= SETTLE_RESET;
		end else if (cfg_wr_en) begin
			settle_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			col_s1 <= col_levels;
		end
	end

	// lowest numbered pressed column
	always_comb begin
		low_found = 1'b1;
		if (!col_s1[0]) begin
			low_col = 2'd0;
		end else if (!col_s1[1]) begin
			low_col = 2'd1;
		end else if (!col_s1[2]) begin
			low_col = 2'd2;
		end else if (!col_s1[3]) begin
			low_col = 2'd3;
		end else begin
			low_col   = 2'd0;
			low_found = 1'b0;
		end
	end

	// key lookup and the times-ten update as shift and add
	assign code      = key_ascii(row_q, held_col_q);
	assign is_digit  = (code >= ASCII_0) && (code <= ASCII_9);
	assign digit_val = 4'(code - ASCII_0);
	assign acc_x10   = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0};

	always_comb begin
		phase_d      = phase_q;
		row_d        = row_q;
		settle_cnt_d = settle_cnt_q;
		held_col_d   = held_col_q;
		acc_d        = acc_q;

		res_d.row_drive    = ~(4'b0001 << row_q);
		res_d.key_valid    = 1'b0;
		res_d.key_code     = 7'd0;
		res_d.digit_taken  = 1'b0;
		res_d.entry_done   = 1'b0;
		res_d.number_value = acc_q;

		case (phase_q)
			PHASE_SETTLE: begin
				if (settle_cnt_q < settle_ticks_q) begin
					settle_cnt_d = settle_cnt_q + 16'd1;
				end else if (low_found) begin
					// key down, watch this column until it lets go
					held_col_d = low_col;
					phase_d    = PHASE_HOLD;
				end else begin
					row_d        = row_q + 2'd1;
					settle_cnt_d = 16'd0;
				end
			end
			PHASE_HOLD: begin
				if (col_s1[held_col_q]) begin
					// released: report it and rescan from the top row
					res_d.key_valid = 1'b1;
					res_d.key_code  = code;
					if (is_digit) begin
						acc_d              = acc_x10 + {28'd0, digit_val};
						res_d.digit_taken  = 1'b1;
						res_d.number_value = acc_x10 + {28'd0, digit_val};
					end else begin
						acc_d            = 32'd0;
						res_d.entry_done = 1'b1;
					end
					row_d        = 2'd0;
					settle_cnt_d = 16'd0;
					phase_d      = PHASE_SETTLE;
				end
			end
			default: begin
				phase_d = PHASE_SETTLE;
			end
		endcase
	end

	// scan state advances with each beat that reaches the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PHASE_SETTLE;
			row_q        <= 2'd0;
			settle_cnt_q <= 16'd0;
			held_col_q   <= 2'd0;
			acc_q        <= 32'd0;
		end else if (adv_s1) begin
			phase_q      <= phase_d;
			row_q        <= row_d;
			settle_cnt_q <= settle_cnt_d;
			held_col_q   <= held_col_d;
			acc_q        <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid    = vld_s2;
	assign row_drive    = res_s2.row_drive;
	assign key_valid    = res_s2.key_valid;
	assign key_code     = res_s2.key_code;
	assign digit_taken  = res_s2.digit_taken;
	assign entry_done   = res_s2.entry_done;
	assign number_value = res_s2.number_value;

	// a report is either a digit or an end of entry, never both
	`ASSERT_NEVER(a_digit_and_done, vld_s2 && res_s2.digit_taken && res_s2.entry_done, "digit and end of entry together")
	`ASSERT_CLK(a_valid_means_report, vld_s2 |-> (res_s2.key_valid == (res_s2.digit_taken || res_s2.entry_done)), "key report without digit or end")
	// exactly one row driven low
	`ASSERT_CLK(a_one_row_low, vld_s2 |-> $onehot(~res_s2.row_drive), "row drive not one-cold")
	// the number is cleared once a finished entry is shown
	`ASSERT_CLK(a_done_clears, (vld_s2 && res_s2.entry_done) |-> (acc_q == 32'd0), "number not cleared after entry")
	// after any report the scan restarts settling on the top row
	`ASSERT_CLK(a_restart_top, (vld_s2 && res_s2.key_valid) |-> (row_q == 2'd0 && phase_q == PHASE_SETTLE), "scan did not restart")

endmodule
